// ----- src/pso_pkg.sv -----
// Shared types and constants for the priority scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package pso_pkg;

    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int TIME_W   = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Depth of the command queue between front and back.
    localparam int QDEPTH   = 4;
    localparam int QA_W     = $clog2(QDEPTH);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    typedef struct packed {
        t_entry ent;
        logic   last;
        logic   drop;   // table already full for this batch
    } t_cmd;

endpackage

`default_nettype wire

// ----- src/pso_front.sv -----
// Front end: input handshake, per-batch item count and overflow classification.
// Depends on pso_pkg; feeds pso_queue.
`default_nettype none

module pso_front #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [7:0]                 i_process_id,
    input  wire logic [15:0]                i_burst_time,
    input  wire logic [7:0]                 i_priority_level,
    input  wire logic                       i_last_process,
    input  wire logic                       i_full,
    output logic                            o_push,
    output pso_pkg::t_cmd                   o_cmd
);
    import pso_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             drop;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign drop    = (r_count == CNT_W'(MAX_PROCS));

    assign o_cmd.ent.id    = i_process_id;
    assign o_cmd.ent.burst = i_burst_time;
    assign o_cmd.ent.prio  = i_priority_level;
    assign o_cmd.last      = i_last_process;
    assign o_cmd.drop      = drop;

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (i_last_process) begin
                n_count = '0;
            end else if (!drop) begin
                n_count = CNT_W'(r_count + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- src/pso_queue.sv -----
// Small FIFO of classified load commands between front and back.
// Depends on pso_pkg.
`default_nettype none

module pso_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  pso_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output pso_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);
    import pso_pkg::*;

    t_cmd            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wptr;
    logic [QA_W-1:0] r_rptr;
    logic [QA_W:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (QA_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= QA_W'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= QA_W'(r_rptr + 1'b1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= (QA_W+1)'(r_cnt + 1'b1);
                2'b01:   r_cnt <= (QA_W+1)'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/pso_back.sv -----
// Back end: process table, sequential min-priority scan and result register.
// Depends on pso_pkg; drains pso_queue.
`default_nettype none

module pso_back #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  pso_pkg::t_cmd      i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_sched_id,
    output logic [19:0]        o_start_time,
    output logic [19:0]        o_finish_time,
    output logic               o_last_result,
    output logic               o_batch_overflow
);
    import pso_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    t_entry r_mem [MAX_PROCS];

    logic [1:0]           r_state,     n_state;
    logic [CNT_W-1:0]     r_count,     n_count;
    logic [CNT_W-1:0]     r_total,     n_total;
    logic                 r_ovf,       n_ovf;
    logic [MAX_PROCS-1:0] r_pending,   n_pending;
    logic [CNT_W-1:0]     r_scan_idx,  n_scan_idx;
    logic                 r_rd_valid,  n_rd_valid;
    logic [IDX_W-1:0]     r_rd_idx,    n_rd_idx;
    t_entry               r_rd_entry;
    logic                 r_best_found, n_best_found;
    logic [IDX_W-1:0]     r_best_idx,  n_best_idx;
    t_entry               r_best,      n_best;
    logic [CNT_W-1:0]     r_k,         n_k;
    logic [TIME_W-1:0]    r_running,   n_running;
    logic                 r_out_valid, n_out_valid;
    logic [ID_W-1:0]      r_out_id,    n_out_id;
    logic [TIME_W-1:0]    r_out_start, n_out_start;
    logic [TIME_W-1:0]    r_out_finish, n_out_finish;
    logic                 r_out_last,  n_out_last;
    logic                 r_out_ovf,   n_out_ovf;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_W:0]      sum;
    logic [TIME_W-1:0]    finish;
    logic                 slot_free;
    logic                 last_pick;
    logic                 emit_fire;

    assign wr_addr   = r_count[IDX_W-1:0];
    assign rd_addr   = r_scan_idx[IDX_W-1:0];
    assign sum       = {1'b0, r_running} + (TIME_W+1)'(r_best.burst);
    assign finish    = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign slot_free = !r_out_valid || i_ready;
    assign last_pick = (r_k == CNT_W'(r_total - 1'b1));
    assign emit_fire = (r_state == ST_EMIT) && slot_free;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_ovf        = r_ovf;
        n_pending    = r_pending;
        n_scan_idx   = r_scan_idx;
        n_rd_valid   = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_best_found = r_best_found;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_k          = r_k;
        n_running    = r_running;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_id     = r_out_id;
        n_out_start  = r_out_start;
        n_out_finish = r_out_finish;
        n_out_last   = r_out_last;
        n_out_ovf    = r_out_ovf;
        o_pop        = 1'b0;
        wr_en        = 1'b0;

        // compare stage of the scan: strict less-than keeps the earliest on a tie
        if (r_rd_valid && r_pending[r_rd_idx] &&
            (!r_best_found || r_rd_entry.prio < r_best.prio)) begin
            n_best_found = 1'b1;
            n_best_idx   = r_rd_idx;
            n_best       = r_rd_entry;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (!i_cmd.drop) begin
                        wr_en                = 1'b1;
                        n_pending[wr_addr]   = 1'b1;
                        n_count              = CNT_W'(r_count + 1'b1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_cmd.last) begin
                        n_total      = i_cmd.drop ? r_count : CNT_W'(r_count + 1'b1);
                        n_state      = ST_SCAN;
                        n_scan_idx   = '0;
                        n_best_found = 1'b0;
                        n_k          = '0;
                        n_running    = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan_idx < r_total) begin
                    n_rd_valid = 1'b1;
                    n_rd_idx   = rd_addr;
                    n_scan_idx = CNT_W'(r_scan_idx + 1'b1);
                end else if (!r_rd_valid) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid            = 1'b1;
                    n_out_id               = r_best.id;
                    n_out_start            = r_running;
                    n_out_finish           = finish;
                    n_out_last             = last_pick;
                    n_out_ovf              = r_ovf;
                    n_pending[r_best_idx]  = 1'b0;
                    n_running              = finish;
                    n_k                    = CNT_W'(r_k + 1'b1);
                    n_best_found           = 1'b0;
                    n_scan_idx             = '0;
                    if (last_pick) begin
                        n_pending = '0;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_running = '0;
                        n_state   = ST_LOAD;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // table storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.ent;
        end
        r_rd_entry <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_count      <= '0;
            r_total      <= '0;
            r_ovf        <= 1'b0;
            r_pending    <= '0;
            r_scan_idx   <= '0;
            r_rd_valid   <= 1'b0;
            r_best_found <= 1'b0;
            r_k          <= '0;
            r_running    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_total      <= n_total;
            r_ovf        <= n_ovf;
            r_pending    <= n_pending;
            r_scan_idx   <= n_scan_idx;
            r_rd_valid   <= n_rd_valid;
            r_best_found <= n_best_found;
            r_k          <= n_k;
            r_running    <= n_running;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_best_idx   <= n_best_idx;
        r_best       <= n_best;
        r_out_id     <= n_out_id;
        r_out_start  <= n_out_start;
        r_out_finish <= n_out_finish;
        r_out_last   <= n_out_last;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_valid          = r_out_valid;
    assign o_sched_id       = r_out_id;
    assign o_start_time     = r_out_start;
    assign o_finish_time    = r_out_finish;
    assign o_last_result    = r_out_last;
    assign o_batch_overflow = r_out_ovf;

    a_emit_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_best_found)
        else $error("emit state without a selected entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PROCS))
        else $error("table count beyond capacity");

    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_finish >= r_out_start))
        else $error("finish time before start time");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && last_pick) |=> (r_count == '0 && r_pending == '0 && !r_ovf))
        else $error("table not cleared after final result");

endmodule

`default_nettype wire

// ----- src/priority_scheduler_order.sv -----
// Non-preemptive priority scheduler. Loading: one item per cycle into a 4-entry queue,
// while the queue has room (o_ready drops when it is full). After the item marked last,
// each result is found by a one-entry-per-cycle scan of the N loaded entries (N = loaded
// entries) through the table's single read port.
// Reset (synchronous, active low) empties the queue and the table; no clearing pass.
// Depends on pso_pkg, pso_front, pso_queue, pso_back.
`default_nettype none

module priority_scheduler_order #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_process_id,
    input  wire logic [15:0] i_burst_time,
    input  wire logic [7:0]  i_priority_level,
    input  wire logic        i_last_process,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_sched_id,
    output logic [19:0]      o_start_time,
    output logic [19:0]      o_finish_time,
    output logic             o_last_result,
    output logic             o_batch_overflow
);
    import pso_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    pso_front #(.MAX_PROCS(MAX_PROCS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_process_id     (i_process_id),
        .i_burst_time     (i_burst_time),
        .i_priority_level (i_priority_level),
        .i_last_process   (i_last_process),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    pso_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    pso_back #(.MAX_PROCS(MAX_PROCS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sched_id       (o_sched_id),
        .o_start_time     (o_start_time),
        .o_finish_time    (o_finish_time),
        .o_last_result    (o_last_result),
        .o_batch_overflow (o_batch_overflow)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for priority_scheduler_order: loads random and corner-case batches and checks
// each emitted schedule slot against a priority-order model with earliest-loaded tie-break.
// Depends on pso_pkg and the priority_scheduler_order RTL.

module tb_top;

    import pso_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start_t;
        logic [TIME_W-1:0] finish_t;
        logic              last;
        logic              ovf;
    } slot_t;

    // Holds the process table and the queue of schedule slots still owed by the block.
    class schedule_sb;
        t_entry           procs[TABLE_DEPTH];
        bit               waiting[TABLE_DEPTH];
        int               loaded_cnt;
        bit               dropped;
        slot_t            slot_q[$];
        int               errors;

        function new();
            loaded_cnt = 0;
            dropped    = 0;
            errors     = 0;
        endfunction

        function int pending();
            return slot_q.size();
        endfunction

        function void load_process(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                                   logic [PRIO_W-1:0] prio, logic last);
            if (loaded_cnt < TABLE_DEPTH) begin
                procs[loaded_cnt].id    = id;
                procs[loaded_cnt].burst = burst;
                procs[loaded_cnt].prio  = prio;
                waiting[loaded_cnt]     = 1'b1;
                loaded_cnt++;
            end else begin
                dropped = 1'b1;
            end
            if (last)
                build_schedule();
        endfunction

        function void build_schedule();
            logic [TIME_W-1:0] now;
            logic [TIME_W:0]   sum;
            int                best;
            slot_t             s;
            now = '0;
            for (int k = 0; k < loaded_cnt; k++) begin
                best = -1;
                // strict less-than: earliest loaded entry keeps a tie
                for (int i = 0; i < loaded_cnt; i++)
                    if (waiting[i] && (best < 0 || procs[i].prio < procs[best].prio))
                        best = i;
                sum        = {1'b0, now} + (TIME_W+1)'(procs[best].burst);
                s.id       = procs[best].id;
                s.start_t  = now;
                s.finish_t = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
                s.last     = (k == loaded_cnt - 1);
                s.ovf      = dropped;
                slot_q.push_back(s);
                waiting[best] = 1'b0;
                now = s.finish_t;
            end
            loaded_cnt = 0;
            dropped    = 1'b0;
        endfunction

        function void check_slot(slot_t got);
            slot_t exp_s;
            if (slot_q.size() == 0) begin
                $display("%0t: unexpected result id=%0d start=%0d finish=%0d last=%0b ovf=%0b",
                         $time, got.id, got.start_t, got.finish_t, got.last, got.ovf);
                errors++;
                return;
            end
            exp_s = slot_q.pop_front();
            if (got.id !== exp_s.id) begin
                $display("%0t: sched_id expected %0d got %0d", $time, exp_s.id, got.id);
                errors++;
            end
            if (got.start_t !== exp_s.start_t) begin
                $display("%0t: start_time expected %0d got %0d", $time,
                         exp_s.start_t, got.start_t);
                errors++;
            end
            if (got.finish_t !== exp_s.finish_t) begin
                $display("%0t: finish_time expected %0d got %0d", $time,
                         exp_s.finish_t, got.finish_t);
                errors++;
            end
            if (got.last !== exp_s.last) begin
                $display("%0t: last_result expected %0b got %0b", $time, exp_s.last, got.last);
                errors++;
            end
            if (got.ovf !== exp_s.ovf) begin
                $display("%0t: batch_overflow expected %0b got %0b", $time, exp_s.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_ready;
    logic [ID_W-1:0]   i_process_id     = '0;
    logic [BURST_W-1:0] i_burst_time    = '0;
    logic [PRIO_W-1:0] i_priority_level = '0;
    logic              i_last_process   = 1'b0;
    logic              o_valid;
    logic              i_ready          = 1'b0;
    logic [ID_W-1:0]   o_sched_id;
    logic [TIME_W-1:0] o_start_time;
    logic [TIME_W-1:0] o_finish_time;
    logic              o_last_result;
    logic              o_batch_overflow;

    int send_idle_pct = 37;
    int recv_idle_pct = 66;
    int cycle_cnt     = 0;
    int random_sent   = 0;

    schedule_sb sb = new();

    priority_scheduler_order #(.MAX_PROCS(TABLE_DEPTH)) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_process_id     (i_process_id),
        .i_burst_time     (i_burst_time),
        .i_priority_level (i_priority_level),
        .i_last_process   (i_last_process),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sched_id       (o_sched_id),
        .o_start_time     (o_start_time),
        .o_finish_time    (o_finish_time),
        .o_last_result    (o_last_result),
        .o_batch_overflow (o_batch_overflow)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_slot({o_sched_id, o_start_time, o_finish_time,
                           o_last_result, o_batch_overflow});
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_process(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                                logic [PRIO_W-1:0] prio, logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid          <= 1'b0;
            i_process_id     <= ID_W'($urandom);
            i_burst_time     <= BURST_W'($urandom);
            i_priority_level <= PRIO_W'($urandom);
            i_last_process   <= 1'($urandom);
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_process_id     <= id;
        i_burst_time     <= burst;
        i_priority_level <= prio;
        i_last_process   <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.load_process(id, burst, prio, last);
        @(negedge i_clk);
    endtask

    function automatic logic [BURST_W-1:0] pick_burst();
        case ($urandom_range(0, 3))
            0:       return BURST_W'($urandom_range(0, 31));
            1:       return {BURST_W{1'b1}} - BURST_W'($urandom_range(0, 3));
            default: return BURST_W'($urandom);
        endcase
    endfunction

    task automatic random_batch();
        int  size;
        bit  narrow;
        logic [PRIO_W-1:0] prio;
        // mostly batches that fit; some spill past the table
        size   = ($urandom_range(0, 7) == 0) ? $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 4)
                                             : $urandom_range(1, TABLE_DEPTH);
        narrow = $urandom_range(0, 1);
        for (int j = 0; j < size; j++) begin
            prio = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
            if (narrow && $urandom_range(0, 1))
                prio = ~prio;
            send_process(ID_W'($urandom), pick_burst(), prio, j == size - 1);
            random_sent++;
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single process, zero burst, extreme id and most urgent level
        send_process(8'hFF, 16'h0000, 8'h00, 1'b1);

        // ties keep load order; least urgent loaded first, most urgent loaded last
        send_process(8'h01, 16'd100, 8'hFF, 1'b0);
        send_process(8'h00, 16'hFFFF, 8'h80, 1'b0);
        send_process(8'h5A, 16'hFFFF, 8'h80, 1'b0);
        send_process(8'hA5, 16'h0000, 8'h80, 1'b0);
        send_process(8'h7E, 16'h0001, 8'h00, 1'b1);

        // full table of maximum bursts, then a dropped item that closes the batch
        for (int j = 0; j < TABLE_DEPTH; j++)
            send_process(ID_W'(j), 16'hFFFF, PRIO_W'(15 - j / 2), 1'b0);
        send_process(8'hEE, 16'h1234, 8'h00, 1'b1);

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (random_sent >= RANDOM_ITEMS / 3) begin
                send_idle_pct = 66;
                recv_idle_pct = 37;
            end
            random_batch();
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
